// ===== sv/kdc_pkg.sv =====
// Shared types, constants and register indexes of the key debounce and click classifier.
package kdc_pkg;

   localparam int LANE_MAX         = 8;
   localparam int NUM_KEYS_DEFAULT = 8;

   localparam int LEVELS_WIDTH = 8;
   localparam int EVENTS_WIDTH = 16;
   localparam int MASK_WIDTH   = 8;
   localparam int EVENT_WIDTH  = 2;

   localparam int DEBOUNCE_WIDTH = 8;
   localparam int LONG_WIDTH     = 16;
   localparam int WINDOW_WIDTH   = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTLE_LEN   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_TICKS = 2'd2;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 8'd2;
   localparam logic [LONG_WIDTH-1:0]     LONG_RESET     = 16'd100;
   localparam logic [WINDOW_WIDTH-1:0]   WINDOW_RESET   = 16'd30;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] settle_len;
      logic [LONG_WIDTH-1:0]     hold_limit;
      logic [WINDOW_WIDTH-1:0]   double_window_ticks;
   } cfg_type;

endpackage

// ===== sv/kdc_if.sv =====
// Valid/ready channel interfaces for the tick input and the event result.
interface kdc_req_if import kdc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [LEVELS_WIDTH-1:0] raw_levels;

   modport source (output valid, output raw_levels, input ready);
   modport sink   (input valid, input raw_levels, output ready);
endinterface

interface kdc_rsp_if import kdc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [EVENTS_WIDTH-1:0] key_events;
   logic [MASK_WIDTH-1:0]   event_mask;

   modport source (output valid, output key_events, output event_mask, input ready);
   modport sink   (input valid, input key_events, input event_mask, output ready);
endinterface

// ===== sv/kdc_lane.sv =====
// One key lane: debounce counter, hold and gap timers and the four-phase click machine.
module kdc_lane
   import kdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      fire,
   input  logic      level,
   input  cfg_type   cfg,
   output event_type ev
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESSED = 2'd1,
      PH_WAIT    = 2'd2,
      PH_LONG    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      IN_NONE = 3'd0,
      IN_DOWN = 3'd1,
      IN_UP   = 3'd2,
      IN_LONG = 3'd3,
      IN_GAP  = 3'd4
   } kind_type;

   phase_type                 phase_ff, phase_in;
   logic                      settled_ff, settled_in;
   logic [DEBOUNCE_WIDTH-1:0] bounce_ff, bounce_in;
   logic [LONG_WIDTH-1:0]     hold_ff, hold_in;
   logic [WINDOW_WIDTH-1:0]   gap_ff, gap_in;

   logic [DEBOUNCE_WIDTH:0]   bounce_next;
   logic [LONG_WIDTH:0]       hold_next;
   logic [WINDOW_WIDTH:0]     gap_next;
   kind_type                  kind;

   assign bounce_next = {1'b0, bounce_ff} + 1'b1;
   assign hold_next   = {1'b0, hold_ff} + 1'b1;
   assign gap_next    = {1'b0, gap_ff} + 1'b1;

   always_comb begin
      kind       = IN_NONE;
      settled_in = settled_ff;
      bounce_in  = bounce_ff;
      hold_in    = hold_ff;
      gap_in     = gap_ff;
      phase_in   = phase_ff;
      ev         = EV_NONE;

      if (level != settled_ff) begin
         if (bounce_next >= {1'b0, cfg.settle_len}) begin
            bounce_in  = '0;
            settled_in = level;
            kind       = level ? IN_DOWN : IN_UP;
         end else begin
            bounce_in = bounce_next[DEBOUNCE_WIDTH-1:0];
         end
      end else begin
         bounce_in = '0;
      end

      if (kind == IN_NONE) begin
         if (phase_ff == PH_PRESSED) begin
            if (hold_next >= {1'b0, cfg.hold_limit}) begin
               hold_in = '0;
               kind    = IN_LONG;
            end else begin
               hold_in = hold_next[LONG_WIDTH-1:0];
            end
         end else if (phase_ff == PH_WAIT) begin
            if (gap_next >= {1'b0, cfg.double_window_ticks}) begin
               gap_in = '0;
               kind   = IN_GAP;
            end else begin
               gap_in = gap_next[WINDOW_WIDTH-1:0];
            end
         end
      end

      case (phase_ff)
         PH_IDLE: begin
            if (kind == IN_DOWN) begin
               phase_in = PH_PRESSED;
               hold_in  = '0;
            end
         end
         PH_PRESSED: begin
            if (kind == IN_UP) begin
               phase_in = PH_WAIT;
               gap_in   = '0;
            end else if (kind == IN_LONG) begin
               phase_in = PH_LONG;
               ev       = EV_LONG;
            end
         end
         PH_WAIT: begin
            if (kind == IN_DOWN) begin
               phase_in = PH_IDLE;
               ev       = EV_DOUBLE;
            end else if (kind == IN_GAP) begin
               phase_in = PH_IDLE;
               ev       = EV_CLICK;
            end
         end
         default: begin
            if (kind == IN_UP) begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         settled_ff <= 1'b0;
         bounce_ff  <= '0;
         hold_ff    <= '0;
         gap_ff     <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         settled_ff <= settled_in;
         bounce_ff  <= bounce_in;
         hold_ff    <= hold_in;
         gap_ff     <= gap_in;
      end
   end

endmodule

// ===== sv/kdc_merge.sv =====
// Merging stage: packs the lane events into one result and buffers it in an output and skid register.
module kdc_merge
   import kdc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  event_type               lane_ev [LANE_MAX],
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [EVENTS_WIDTH-1:0] key_events,
   output logic [MASK_WIDTH-1:0]   event_mask
);

   logic [EVENTS_WIDTH-1:0] events_in;
   logic [MASK_WIDTH-1:0]   mask_in;

   logic                    out_valid_ff;
   logic [EVENTS_WIDTH-1:0] out_events_ff;
   logic [MASK_WIDTH-1:0]   out_mask_ff;
   logic                    skid_valid_ff;
   logic [EVENTS_WIDTH-1:0] skid_events_ff;
   logic [MASK_WIDTH-1:0]   skid_mask_ff;
   logic                    take;

   always_comb begin
      events_in = '0;
      mask_in   = '0;
      for (int k = 0; k < LANE_MAX; k++) begin
         events_in[EVENT_WIDTH*k +: EVENT_WIDTH] = lane_ev[k];
         mask_in[k]                             = (lane_ev[k] != EV_NONE);
      end
   end

   assign take       = out_valid_ff && out_ready;
   assign in_ready   = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign key_events = out_events_ff;
   assign event_mask = out_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (fire) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (!out_valid_ff || take) begin
            out_events_ff <= events_in;
            out_mask_ff   <= mask_in;
         end else begin
            skid_events_ff <= events_in;
            skid_mask_ff   <= mask_in;
         end
      end else if (take && skid_valid_ff) begin
         out_events_ff <= skid_events_ff;
         out_mask_ff   <= skid_mask_ff;
      end
   end

endmodule

// ===== sv/key_debounce_click_classifier.sv =====
// Top level of the key debounce and click classifier.
//
// Each transaction on req_bus is one tick carrying the raw levels of the keys,
// one bit per key. Each transaction on rsp_bus carries the events of that tick:
// two bits per key in key_events (none, click, double click, long press) and
// one bit per key in event_mask. Every tick gives exactly one result, in order.
// Every key has its own lane with a debounce counter, hold and gap timers and
// a four-phase machine; all lanes update in the cycle the tick is accepted and
// the merging stage packs their events into the output or skid register.
// One tick can be accepted every cycle while req_bus.ready is high. A skid
// register behind the output register lets one more tick enter while the
// receiver stalls; req_bus.ready falls only when both hold a result, and rises
// again the cycle after the receiver takes one. Reset clears all lane state
// and both buffers and loads the default thresholds. The csr_ port writes the
// thresholds; it must be used only while idle, which the block does not
// enforce. Keys at or beyond NUM_KEYS, or beyond eight, never report an event.
module key_debounce_click_classifier
   import kdc_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   kdc_req_if.sink                    req_bus,
   kdc_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int LANES = (NUM_KEYS < LANE_MAX) ? NUM_KEYS : LANE_MAX;

   cfg_type   cfg_ff, cfg_in;
   event_type lane_ev [LANE_MAX];
   logic      fire;
   logic      in_ready;

   assign fire          = req_bus.valid && in_ready;
   assign req_bus.ready = in_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SETTLE_LEN:   cfg_in.settle_len          = csr_wdata[DEBOUNCE_WIDTH-1:0];
            CSR_HOLD_LIMIT:   cfg_in.hold_limit          = csr_wdata[LONG_WIDTH-1:0];
            CSR_WINDOW_TICKS: cfg_in.double_window_ticks = csr_wdata[WINDOW_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_len          <= DEBOUNCE_RESET;
         cfg_ff.hold_limit          <= LONG_RESET;
         cfg_ff.double_window_ticks <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar k = 0; k < LANE_MAX; k++) begin : g_lane
      if (k < LANES) begin : g_used
         kdc_lane u_lane (
            .clock (clock),
            .reset (reset),
            .fire  (fire),
            .level (req_bus.raw_levels[k]),
            .cfg   (cfg_ff),
            .ev    (lane_ev[k])
         );
      end else begin : g_unused
         assign lane_ev[k] = EV_NONE;
      end
   end

   kdc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .lane_ev    (lane_ev),
      .in_ready   (in_ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .key_events (rsp_bus.key_events),
      .event_mask (rsp_bus.event_mask)
   );

endmodule

// ===== sv/kdc_checker.sv =====
// Port-level checker for the key debounce and click classifier, bound to the top level.
module kdc_checker
   import kdc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [EVENTS_WIDTH-1:0] key_events,
   input logic [MASK_WIDTH-1:0]   event_mask
);

   // The block is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled result holds its payload.
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_events) && $stable(event_mask))
      else $error("stalled result changed");

   // A new result appears only after a transaction was accepted.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(reset) |-> $past(req_valid && req_ready))
      else $error("result without an accepted tick");

   // The input only stalls while a result waits at the output.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind key_debounce_click_classifier kdc_checker u_kdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .key_events (rsp_bus.key_events),
   .event_mask (rsp_bus.event_mask)
);

// ===== tb/tb_key_debounce_click_classifier.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the key debounce and click classifier, with its own event predictor.
module tb_key_debounce_click_classifier;
   import kdc_pkg::*;

   localparam int NUM_KEYS    = NUM_KEYS_DEFAULT;
   localparam int LANES       = (NUM_KEYS < LANE_MAX) ? NUM_KEYS : LANE_MAX;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_HOLD    = 320;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 2'd3;

   localparam logic [LEVELS_WIDTH-1:0] DIRECTED_TICKS [20] = '{
      8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h00,
      8'hF0, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [1:0] {PH_IDLE, PH_PRESSED, PH_WAIT, PH_LONG} key_phase_type;
   typedef enum logic [2:0] {TC_NONE, TC_DOWN, TC_UP, TC_LONG, TC_GAP} tick_cause_type;

   typedef struct packed {
      logic [EVENTS_WIDTH-1:0] key_events;
      logic [MASK_WIDTH-1:0]   event_mask;
   } tick_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   kdc_req_if req_bus ();
   kdc_rsp_if rsp_bus ();

   key_debounce_click_classifier #(.NUM_KEYS(NUM_KEYS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [DEBOUNCE_WIDTH-1:0] cfg_debounce = DEBOUNCE_RESET;
   logic [LONG_WIDTH-1:0]     cfg_long     = LONG_RESET;
   logic [WINDOW_WIDTH-1:0]   cfg_window   = WINDOW_RESET;

   logic                      settled        [LANE_MAX] = '{default: 1'b0};
   logic [DEBOUNCE_WIDTH-1:0] debounce_count [LANE_MAX] = '{default: '0};
   logic [LONG_WIDTH-1:0]     hold_count     [LANE_MAX] = '{default: '0};
   logic [WINDOW_WIDTH-1:0]   gap_count      [LANE_MAX] = '{default: '0};
   key_phase_type             lane_phase     [LANE_MAX] = '{default: PH_IDLE};

   tick_result_type expected_events [$];
   int unsigned     event_tally [4] = '{default: 0};
   int unsigned     results_checked = 0;
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;
   bit              no_idle = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic tick_result_type predict_tick(input logic [LEVELS_WIDTH-1:0] raw);
      tick_result_type res;
      tick_cause_type  cause;
      event_type       ev;
      int unsigned     n;
      res = '0;
      for (int k = 0; k < LANES; k++) begin
         cause = TC_NONE;
         ev = EV_NONE;
         if (raw[k] != settled[k]) begin
            n = debounce_count[k] + 1;
            if (n >= cfg_debounce) begin
               debounce_count[k] = '0;
               settled[k] = raw[k];
               cause = raw[k] ? TC_DOWN : TC_UP;
            end else begin
               debounce_count[k] = n[DEBOUNCE_WIDTH-1:0];
            end
         end else begin
            debounce_count[k] = '0;
         end
         if (cause == TC_NONE) begin
            if (lane_phase[k] == PH_PRESSED) begin
               n = hold_count[k] + 1;
               if (n >= cfg_long) begin
                  hold_count[k] = '0;
                  cause = TC_LONG;
               end else begin
                  hold_count[k] = n[LONG_WIDTH-1:0];
               end
            end else if (lane_phase[k] == PH_WAIT) begin
               n = gap_count[k] + 1;
               if (n >= cfg_window) begin
                  gap_count[k] = '0;
                  cause = TC_GAP;
               end else begin
                  gap_count[k] = n[WINDOW_WIDTH-1:0];
               end
            end
         end
         case (lane_phase[k])
            PH_IDLE: if (cause == TC_DOWN) begin
               lane_phase[k] = PH_PRESSED;
               hold_count[k] = '0;
            end
            PH_PRESSED: if (cause == TC_UP) begin
               lane_phase[k] = PH_WAIT;
               gap_count[k] = '0;
            end else if (cause == TC_LONG) begin
               lane_phase[k] = PH_LONG;
               ev = EV_LONG;
            end
            PH_WAIT: if (cause == TC_DOWN) begin
               lane_phase[k] = PH_IDLE;
               ev = EV_DOUBLE;
            end else if (cause == TC_GAP) begin
               lane_phase[k] = PH_IDLE;
               ev = EV_CLICK;
            end
            default: if (cause == TC_UP) begin
               lane_phase[k] = PH_IDLE;
            end
         endcase
         res.key_events[EVENT_WIDTH*k +: EVENT_WIDTH] = ev;
         res.event_mask[k] = (ev != EV_NONE);
         event_tally[ev]++;
      end
      return res;
   endfunction

   function automatic int unsigned pick_hold_length();
      int unsigned db;
      int unsigned r;
      db = (cfg_debounce == 0) ? 1 : cfg_debounce;
      r = $urandom_range(0, 99);
      if (r < 15)
         return $urandom_range(1, db);
      if (r < 65)
         return $urandom_range(db, db + cfg_window + 1);
      return $urandom_range(db, db + cfg_long + 2);
   endfunction

   task automatic send_tick(input logic [LEVELS_WIDTH-1:0] raw);
      while (!no_idle && $urandom_range(0, 99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.raw_levels <= raw;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      expected_events.push_back(predict_tick(raw));
   endtask

   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_SETTLE_LEN:   cfg_debounce = value[DEBOUNCE_WIDTH-1:0];
         CSR_HOLD_LIMIT:   cfg_long = value[LONG_WIDTH-1:0];
         CSR_WINDOW_TICKS: cfg_window = value[WINDOW_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_thresholds(input int unsigned debounce, input int unsigned long_hold,
                                   input int unsigned window);
      wait_for_quiet();
      write_register(CSR_SETTLE_LEN, CSR_DATA_WIDTH'(debounce));
      write_register(CSR_HOLD_LIMIT, CSR_DATA_WIDTH'(long_hold));
      write_register(CSR_WINDOW_TICKS, CSR_DATA_WIDTH'(window));
   endtask

   // Each key holds a level for a random run, mostly long enough to settle.
   task automatic run_gestures(input int count);
      logic [LEVELS_WIDTH-1:0] levels;
      int unsigned             remaining [LEVELS_WIDTH];
      levels = '0;
      foreach (remaining[k])
         remaining[k] = pick_hold_length();
      repeat (count) begin
         for (int k = 0; k < LEVELS_WIDTH; k++) begin
            if (remaining[k] == 0) begin
               levels[k] = ~levels[k];
               remaining[k] = pick_hold_length();
            end
            remaining[k]--;
         end
         if ($urandom_range(0, 99) < 3)
            send_tick(LEVELS_WIDTH'($urandom));
         else
            send_tick(levels);
      end
   endtask

   task automatic test_reset_thresholds();
      run_gestures(200);
   endtask

   task automatic test_directed_events();
      write_thresholds(0, 3, 2);
      foreach (DIRECTED_TICKS[i])
         send_tick(DIRECTED_TICKS[i]);
   endtask

   task automatic test_zero_thresholds();
      write_thresholds(0, 0, 0);
      write_register(CSR_SPARE_INDEX, '1);
      run_gestures(60);
   endtask

   task automatic test_minimum_thresholds();
      write_thresholds(1, 1, 1);
      run_gestures(60);
   endtask

   task automatic test_maximum_thresholds();
      logic [LEVELS_WIDTH-1:0] raw;
      write_thresholds(255, 65535, 65535);
      no_idle = 1'b1;
      for (int t = 0; t < MAX_HOLD; t++) begin
         raw = '0;
         raw[0] = 1'b1;
         raw[1] = (t < 200);
         raw[2] = (((t / 100) % 2) != 0);
         send_tick(raw);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_gestures();
      write_thresholds(3, 24, 10);
      run_gestures(100);
      write_thresholds(1, 8, 5);
      no_idle = 1'b1;
      run_gestures(100);
      no_idle = 1'b0;
      write_thresholds($urandom_range(1, 6), $urandom_range(1, 40), $urandom_range(1, 20));
      run_gestures(100);
      write_thresholds(DEBOUNCE_RESET, LONG_RESET, WINDOW_RESET);
      run_gestures(100);
   endtask

   always @(posedge clock)
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 32);

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected transaction: key_events %h event_mask %h",
                        rsp_bus.key_events, rsp_bus.event_mask);
         end else begin
            want = expected_events.pop_front();
            results_checked++;
            if (rsp_bus.key_events !== want.key_events ||
                rsp_bus.event_mask !== want.event_mask) begin
               error_count++;
               if (error_count <= 10)
                  $display({"Tick %0d: key_events expected %h got %h, ",
                            "event_mask expected %h got %h"},
                           results_checked, want.key_events, rsp_bus.key_events,
                           want.event_mask, rsp_bus.event_mask);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_key_debounce_click_classifier: errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.raw_levels = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_thresholds();
      test_directed_events();
      test_zero_thresholds();
      test_minimum_thresholds();
      test_maximum_thresholds();
      test_random_gestures();
      wait_for_quiet();
      $display("Checked %0d tick results over zero, minimum, default and maximum thresholds.",
               results_checked);
      $display("Predicted %0d clicks, %0d double clicks and %0d long presses.",
               event_tally[EV_CLICK], event_tally[EV_DOUBLE], event_tally[EV_LONG]);
      if (error_count == 0)
         $display("tb_key_debounce_click_classifier: clean");
      else
         $display("tb_key_debounce_click_classifier: errors");
      $finish;
   end

endmodule
